FILE: rtl/core/stb_pkg.sv
// Streebog engine package: shared types, S-box, linear map and round constants.
// No dependencies; used by stb_lps_unit, stb_compress and the top level.
`timescale 1ns / 1ps

package stb_pkg;

   localparam int ROUND_COUNT = 12;
   localparam int WORDS       = 8;
   localparam logic [5:0] BLOCK_LAST = 6'd63;
   localparam logic [63:0] IV_256 = 64'h0101010101010101;
   localparam logic [63:0] ADD_FULL_BLOCK = 64'd512;
   localparam logic [7:0] PAD_MARK = 8'h01;

   typedef enum logic [0:0] {
      CMD_ABSORB = 1'b0,
      CMD_FINISH = 1'b1
   } cmd_type;

   typedef struct packed {
      logic start;
   } cmp_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cmp_sts_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
      8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
      8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
      8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
      8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
      8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
      8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
      8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
      8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
      8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
      8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
      8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
      8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
      8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
      8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
      8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
   };

   // row 0 belongs to the msb of a word
   localparam logic [63:0] LMAT [64] = '{
      64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
      64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
      64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
      64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
      64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
      64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
      64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
      64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
      64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
      64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
      64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
      64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
      64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
      64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
      64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
      64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
   };

   // each row listed from its most significant word down
   localparam logic [63:0] RCONST [ROUND_COUNT][WORDS] = '{
      '{64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
        64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
      '{64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
        64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
      '{64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
        64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
      '{64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
        64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
      '{64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
        64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
      '{64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
        64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
      '{64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
        64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
      '{64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
        64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
      '{64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
        64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
      '{64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
        64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
      '{64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
        64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
      '{64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
        64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}
   };

endpackage

FILE: rtl/core/stb_req_if.sv
// Request channel interface: valid/ready plus command and message byte.
// No dependencies.
`timescale 1ns / 1ps

interface stb_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;

   modport source (output valid, command, data_byte, input ready);
   modport sink   (input valid, command, data_byte, output ready);
endinterface

FILE: rtl/core/stb_rsp_if.sv
// Response channel interface: valid/ready plus one digest word and its tags.
// No dependencies.
`timescale 1ns / 1ps

interface stb_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/core/stb_lps_unit.sv
// Shared LPS unit: one 64-bit output word of S, P and L over a 512-bit state.
// Depends on stb_pkg (SBOX, LMAT).
`timescale 1ns / 1ps

module stb_lps_unit (
   input  logic [511:0] lps_in,
   input  logic [2:0]   word_sel,
   output logic [63:0]  lps_word
);
   import stb_pkg::*;

   // output word i gathers byte i of every input word (the P transpose)
   always_comb begin
      logic [7:0] b;
      lps_word = '0;
      for (int j = 0; j < WORDS; j++) begin
         b = SBOX[lps_in[j*64 + 8*word_sel +: 8]];
         for (int t = 0; t < 8; t++) begin
            if (b[t]) begin
               lps_word = lps_word ^ LMAT[63 - (8*j + t)];
            end
         end
      end
   end
endmodule

FILE: rtl/core/stb_compress.sv
// Compression sequencer g_N: 25 LPS passes through the shared LPS unit.
// Depends on stb_pkg and stb_lps_unit.
`timescale 1ns / 1ps

module stb_compress (
   input  logic                clock,
   input  logic                reset,
   input  stb_pkg::cmp_ctl_type ctl,
   input  logic [511:0]        m_in,
   input  logic [511:0]        n_in,
   input  logic [511:0]        h_in,
   output stb_pkg::cmp_sts_type sts,
   output logic [511:0]        h_out
);
   import stb_pkg::*;

   typedef enum logic [2:0] {
      C_IDLE   = 3'b001,
      C_RUN    = 3'b010,
      C_COMMIT = 3'b100
   } cstate_type;

   typedef enum logic [2:0] {
      PH_KEY0 = 3'b001,
      PH_SR   = 3'b010,
      PH_KR   = 3'b100
   } phase_type;

   cstate_type   state_ff, state_in;
   phase_type    phase_ff, phase_in;
   logic [3:0]   round_ff, round_in;
   logic [2:0]   word_ff, word_in;
   logic         done_ff, done_in;
   logic [511:0] h0_ff, h0_in, m_ff, m_in_r, k_ff, k_in, s_ff, s_in, tmp_ff, tmp_in;
   logic [511:0] lps_src, rc_vec;
   logic [63:0]  lps_word;

   always_comb begin
      for (int q = 0; q < WORDS; q++) begin
         rc_vec[q*64 +: 64] = RCONST[round_ff][7 - q];
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_KEY0: lps_src = k_ff;
         PH_SR:   lps_src = s_ff;
         PH_KR:   lps_src = k_ff ^ rc_vec;
         default: lps_src = k_ff;
      endcase
   end

   stb_lps_unit u_lps (
      .lps_in   (lps_src),
      .word_sel (word_ff),
      .lps_word (lps_word)
   );

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      round_in = round_ff;
      word_in  = word_ff;
      done_in  = 1'b0;
      h0_in    = h0_ff;
      m_in_r   = m_ff;
      k_in     = k_ff;
      s_in     = s_ff;
      tmp_in   = tmp_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (ctl.start) begin
               h0_in    = h_in;
               m_in_r   = m_in;
               k_in     = h_in ^ n_in;
               phase_in = PH_KEY0;
               round_in = '0;
               word_in  = '0;
               state_in = C_RUN;
            end
         end
         C_RUN: begin
            tmp_in[word_ff*64 +: 64] = lps_word;
            word_in = word_ff + 3'd1;
            if (word_ff == 3'd7) begin
               state_in = C_COMMIT;
            end
         end
         C_COMMIT: begin
            state_in = C_RUN;
            unique case (phase_ff)
               PH_KEY0: begin
                  k_in     = tmp_ff;
                  s_in     = m_ff ^ tmp_ff;
                  phase_in = PH_SR;
               end
               PH_SR: begin
                  s_in     = tmp_ff;
                  phase_in = PH_KR;
               end
               PH_KR: begin
                  k_in     = tmp_ff;
                  s_in     = s_ff ^ tmp_ff;
                  phase_in = PH_SR;
                  round_in = round_ff + 4'd1;
                  if (round_ff == 4'(ROUND_COUNT - 1)) begin
                     state_in = C_IDLE;
                     done_in  = 1'b1;
                  end
               end
               default: phase_in = PH_SR;
            endcase
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         phase_ff <= PH_KEY0;
         round_ff <= '0;
         word_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         round_ff <= round_in;
         word_ff  <= word_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      h0_ff  <= h0_in;
      m_ff   <= m_in_r;
      k_ff   <= k_in;
      s_ff   <= s_in;
      tmp_ff <= tmp_in;
   end

   assign sts.busy = (state_ff != C_IDLE);
   assign sts.done = done_ff;
   assign h_out    = h0_ff ^ s_ff ^ m_ff;
endmodule

FILE: rtl/core/streebog_hash_engine.sv
// Streebog hash engine top level: byte buffer, block sequencer, counters, output.
// Depends on stb_pkg, stb_req_if, stb_rsp_if and stb_compress.
`timescale 1ns / 1ps

// channel | dir | payload                                | transaction when
// req_chan| in  | command, data_byte                     | valid && ready
// rsp_chan| out | digest_word, word_index, last_word      | valid && ready
// csr     | in  | csr_wr_data (digest_mode)              | csr_wr_en in S_IDLE
//
// Absorb: one transaction per cycle while ready is high; the 64th byte of a
// block starts a compression: the S_LAUNCH state, S_CMP (25 LPS passes in the
// shared unit), then a word-serial 512-bit add in S_ADD.
// Ready stays low through all of these states.
// Finish: padding in S_PAD, three compressions, then 4 or 8 words.
// Reset (synchronous, high) gives 512-bit mode and the zero IV. A csr write in
// S_IDLE restarts the hash with the IV of the written mode.
// rsp words hold steady while ready is low; no request is taken meanwhile.

module streebog_hash_engine (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   stb_req_if.sink   req_chan,
   stb_rsp_if.source rsp_chan
);
   import stb_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_PAD    = 6'b000010,
      S_LAUNCH = 6'b000100,
      S_CMP    = 6'b001000,
      S_ADD    = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   // which compression of the sequence runs: block, then N, then Sigma
   typedef enum logic [2:0] {
      J_BLOCK = 3'b001,
      J_NCNT  = 3'b010,
      J_SIGMA = 3'b100
   } job_type;

   state_type    state_ff, state_in;
   job_type      job_ff, job_in;
   logic         mode_ff, mode_in;
   logic         fin_ff, fin_in;
   logic         first_ff, first_in;
   logic [5:0]   count_ff, count_in;
   logic [5:0]   len_ff, len_in;
   logic [2:0]   q_ff, q_in;
   logic         cn_ff, cn_in, cs_ff, cs_in;
   logic [511:0] buf_ff, buf_in;
   logic [511:0] h_ff, h_in, n_ff, n_in, sig_ff, sig_in;

   cmp_ctl_type  cmp_ctl;
   cmp_sts_type  cmp_sts;
   logic [511:0] cmp_m, cmp_n, cmp_h;

   logic         req_fire, rsp_fire;
   logic [63:0]  add_word, n_word, s_word, out_word;
   logic [64:0]  n_sum, s_sum;
   logic [2:0]   out_sel;
   logic         out_last;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // compression operands per job; N is zero for the two final passes
   always_comb begin
      unique case (job_ff)
         J_BLOCK: begin cmp_m = buf_ff; cmp_n = n_ff; end
         J_NCNT:  begin cmp_m = n_ff;   cmp_n = '0;   end
         J_SIGMA: begin cmp_m = sig_ff; cmp_n = '0;   end
         default: begin cmp_m = buf_ff; cmp_n = n_ff; end
      endcase
   end

   assign cmp_ctl.start = (state_ff == S_LAUNCH);

   stb_compress u_cmp (
      .clock (clock),
      .reset (reset),
      .ctl   (cmp_ctl),
      .m_in  (cmp_m),
      .n_in  (cmp_n),
      .h_in  (h_ff),
      .sts   (cmp_sts),
      .h_out (cmp_h)
   );

   // word-serial 512-bit adds: N += block length, Sigma += block
   always_comb begin
      if (q_ff == 3'd0) begin
         add_word = fin_ff ? {55'd0, len_ff, 3'b000} : ADD_FULL_BLOCK;
      end else begin
         add_word = '0;
      end
      n_word = n_ff[q_ff*64 +: 64];
      s_word = sig_ff[q_ff*64 +: 64];
      n_sum  = {1'b0, n_word} + {1'b0, add_word} + {64'd0, cn_ff};
      s_sum  = {1'b0, s_word} + {1'b0, buf_ff[q_ff*64 +: 64]} + {64'd0, cs_ff};
   end

   // 256-bit digest is the upper half of the chaining value
   assign out_sel  = mode_ff ? q_ff : (q_ff + 3'd4);
   assign out_last = mode_ff ? (q_ff == 3'd7) : (q_ff == 3'd3);
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         out_word[8*(7-b) +: 8] = h_ff[out_sel*64 + 8*b +: 8];
      end
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      mode_in  = mode_ff;
      fin_in   = fin_ff;
      first_in = first_ff;
      count_in = count_ff;
      len_in   = len_ff;
      q_in     = q_ff;
      cn_in    = cn_ff;
      cs_in    = cs_ff;
      buf_in   = buf_ff;
      h_in     = h_ff;
      n_in     = n_ff;
      sig_in   = sig_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_wr_en) begin
               mode_in  = csr_wr_data;
               h_in     = {WORDS{csr_wr_data ? 64'd0 : IV_256}};
               n_in     = '0;
               sig_in   = '0;
               count_in = '0;
            end else if (req_fire) begin
               job_in = J_BLOCK;
               if (req_chan.command == CMD_FINISH) begin
                  fin_in   = 1'b1;
                  first_in = 1'b1;
                  len_in   = count_ff;
                  state_in = S_PAD;
               end else begin
                  // shift line: the first byte ends in the low byte of word 0
                  fin_in   = 1'b0;
                  buf_in   = {req_chan.data_byte, buf_ff[511:8]};
                  count_in = count_ff + 6'd1;
                  if (count_ff == BLOCK_LAST) begin
                     state_in = S_LAUNCH;
                  end
               end
            end
         end
         S_PAD: begin
            buf_in   = {(first_ff ? PAD_MARK : 8'h00), buf_ff[511:8]};
            first_in = 1'b0;
            count_in = count_ff + 6'd1;
            if (count_ff == BLOCK_LAST) begin
               state_in = S_LAUNCH;
            end
         end
         S_LAUNCH: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (cmp_sts.done) begin
               h_in = cmp_h;
               priority case (1'b1)
                  (job_ff == J_BLOCK): begin
                     q_in     = '0;
                     cn_in    = 1'b0;
                     cs_in    = 1'b0;
                     state_in = S_ADD;
                  end
                  (job_ff == J_NCNT): begin
                     job_in   = J_SIGMA;
                     state_in = S_LAUNCH;
                  end
                  default: begin
                     q_in     = '0;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_ADD: begin
            n_in[q_ff*64 +: 64]   = n_sum[63:0];
            sig_in[q_ff*64 +: 64] = s_sum[63:0];
            cn_in = n_sum[64];
            cs_in = s_sum[64];
            q_in  = q_ff + 3'd1;
            if (q_ff == 3'd7) begin
               if (fin_ff) begin
                  job_in   = J_NCNT;
                  state_in = S_LAUNCH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_OUT: begin
            if (rsp_fire) begin
               q_in = q_ff + 3'd1;
               if (out_last) begin
                  h_in     = {WORDS{mode_ff ? 64'd0 : IV_256}};
                  n_in     = '0;
                  sig_in   = '0;
                  count_in = '0;
                  fin_in   = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         job_ff   <= J_BLOCK;
         mode_ff  <= 1'b1;
         fin_ff   <= 1'b0;
         first_ff <= 1'b0;
         count_ff <= '0;
         len_ff   <= '0;
         q_ff     <= '0;
         cn_ff    <= 1'b0;
         cs_ff    <= 1'b0;
         h_ff     <= '0;
         n_ff     <= '0;
         sig_ff   <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         mode_ff  <= mode_in;
         fin_ff   <= fin_in;
         first_ff <= first_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         q_ff     <= q_in;
         cn_ff    <= cn_in;
         cs_ff    <= cs_in;
         h_ff     <= h_in;
         n_ff     <= n_in;
         sig_ff   <= sig_in;
      end
   end

   // block buffer payload needs no reset
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign req_chan.ready       = (state_ff == S_IDLE) && !csr_wr_en;
   assign rsp_chan.valid       = (state_ff == S_OUT);
   assign rsp_chan.digest_word = out_word;
   assign rsp_chan.word_index  = q_ff;
   assign rsp_chan.last_word   = out_last;
endmodule

FILE: rtl/core/stb_checker.sv
// Port-level checker for the Streebog engine, bound to the top level.
// Depends on streebog_hash_engine port names only.
`timescale 1ns / 1ps

module stb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  word_index,
   input logic        last_word
);
   // no request taken while digest words are pending
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while digest pending");

   // an accepted request never yields a digest word on the next cycle
   a_req_then_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("digest word right after request");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && last_word) |-> (word_index == 3'd3 || word_index == 3'd7))
      else $error("last word at wrong index");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !last_word) |=>
         (rsp_valid && word_index == $past(word_index) + 3'd1))
      else $error("digest word index did not advance");

   a_end_of_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && last_word) |=> !rsp_valid)
      else $error("response after last word");
endmodule

bind streebog_hash_engine stb_checker u_stb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .word_index (rsp_chan.word_index),
   .last_word  (rsp_chan.last_word)
);
